### hdl/two_axis_stepper_positioner_core_macros.svh
// Assertion macros shared by the stepper positioner modules.
`ifndef TWO_AXIS_STEPPER_POSITIONER_CORE_MACROS_SVH
`define TWO_AXIS_STEPPER_POSITIONER_CORE_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define STP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define STP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/stp_pkg.sv
// Shared types, constants and helpers of the stepper positioner.
package stp_pkg;

  typedef enum logic [1:0] {
    DIR_FORWARD  = 2'd0,
    DIR_BACKWARD = 2'd1,
    DIR_STOP     = 2'd2
  } dir_t;

  // Per-axis control from the top level for one processed item.
  typedef struct packed {
    logic load;
    logic is_move;
    logic serve;
  } axis_ctl_t;

  localparam logic [15:0] PATTERNS_RESET = 16'h9A65;
  localparam int          APB_ADDR_W     = 3;
  localparam logic        REG_PHASE_PATTERNS = 1'b0;

  function automatic logic [3:0] pick_pattern(input logic [15:0] pats,
                                              input logic [1:0]  sel);
    logic [3:0] pat;
    case (sel)
      2'd0:    pat = pats[3:0];
      2'd1:    pat = pats[7:4];
      2'd2:    pat = pats[11:8];
      default: pat = pats[15:12];
    endcase
    return pat;
  endfunction

endpackage

### hdl/stp_cfg.sv
// APB register holding the four shared coil patterns.
module stp_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [stp_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  output logic [15:0]                     patterns
);

  logic reg_hit;

  assign reg_hit = (paddr[stp_pkg::APB_ADDR_W-1] == stp_pkg::REG_PHASE_PATTERNS);
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? {16'd0, patterns} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      patterns <= stp_pkg::PATTERNS_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      patterns <= pwdata[15:0];
    end
  end

endmodule

### hdl/stp_axis.sv
// State and step logic of one stepper axis.
module stp_axis (
  input  logic                clk,
  input  logic                rst,
  input  stp_pkg::axis_ctl_t  ctl,
  input  logic signed [15:0]  target,
  input  logic [15:0]         patterns,
  output logic signed [15:0]  position,
  output logic                moving,
  output logic [3:0]          coil_nibble
);

  stp_pkg::dir_t dir, dir_next;
  logic [15:0] distance, distance_next;
  logic [15:0] step_count, step_count_next;
  logic [1:0]  phase, phase_next;
  logic signed [15:0] position_next;
  logic [15:0] count_stepped;
  logic [1:0]  pattern_sel;

  always_comb begin
    case (dir)
      stp_pkg::DIR_FORWARD, stp_pkg::DIR_BACKWARD: moving = 1'b1;
      default:                                     moving = 1'b0;
    endcase
  end

  // Going backward walks the table in reverse, which is the inverted phase.
  assign pattern_sel = (dir == stp_pkg::DIR_FORWARD) ? phase : ~phase;

  always_comb begin
    dir_next        = dir;
    distance_next   = distance;
    step_count_next = step_count;
    phase_next      = phase;
    position_next   = position;
    count_stepped   = 16'd0;
    coil_nibble     = 4'd0;
    if (ctl.is_move) begin
      if (target > position) begin
        dir_next      = stp_pkg::DIR_FORWARD;
        distance_next = target - position;
      end else if (target < position) begin
        dir_next      = stp_pkg::DIR_BACKWARD;
        distance_next = position - target;
      end else begin
        dir_next      = stp_pkg::DIR_STOP;
        distance_next = 16'd0;
      end
    end else if (ctl.serve) begin
      if (moving) begin
        count_stepped = step_count + 16'd1;
        coil_nibble   = stp_pkg::pick_pattern(patterns, pattern_sel);
        phase_next    = phase + 2'd1;
        if (dir == stp_pkg::DIR_FORWARD) begin
          position_next = position + 16'sd1;
        end else begin
          position_next = position - 16'sd1;
        end
      end
      step_count_next = count_stepped;
      if (count_stepped == distance) begin
        dir_next        = stp_pkg::DIR_STOP;
        distance_next   = 16'd0;
        step_count_next = 16'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dir        <= stp_pkg::DIR_STOP;
      distance   <= 16'd0;
      step_count <= 16'd0;
      phase      <= 2'd0;
      position   <= 16'sd0;
    end else if (ctl.load) begin
      dir        <= dir_next;
      distance   <= distance_next;
      step_count <= step_count_next;
      phase      <= phase_next;
      position   <= position_next;
    end
  end

  `include "two_axis_stepper_positioner_core_macros.svh"

  // A distinct target always gives a non-zero distance, so a moving axis never has none.
  `STP_ASSERT_NOW(a_moving_has_distance, moving, distance != 16'd0,
                  "moving axis with zero distance")
  `STP_ASSERT_NOW(a_stopped_no_distance, dir == stp_pkg::DIR_STOP, distance == 16'd0,
                  "stopped axis keeps a distance")
  `STP_ASSERT_NEXT(a_serve_stopped_holds, ctl.load && ctl.serve && !moving,
                   position == $past(position) && phase == $past(phase),
                   "stopped axis stepped")

endmodule

### hdl/two_axis_stepper_positioner_core.sv
// Top level of the two-axis stepper positioner: input register, axes and coil port.
//
// Each transfer on the item channel is a move (new targets for both axes) or a tick
// that serves X and Y in turn and steps the served axis, if moving, by one full step.
// The block accepts one item in every cycle unless item_stall is high; the result of
// an item appears on the result channel at the edge at which the item leaves the input
// register. Behind the single input register, the axis state registers double as the
// result register: while a result is stalled, at most one further item waits in the
// input register and item_stall rises. Coil patterns are written through the APB port
// at addresses 0 to 3 while idle, a rule for the user that the block does not enforce.
module two_axis_stepper_positioner_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            item_valid,
  output logic                            item_stall,
  input  logic                            operation,
  input  logic signed [15:0]              target_x,
  input  logic signed [15:0]              target_y,
  output logic                            result_valid,
  input  logic                            result_stall,
  output logic [7:0]                      coil_port,
  output logic                            served_axis,
  output logic signed [15:0]              x_position,
  output logic signed [15:0]              y_position,
  output logic                            x_moving,
  output logic                            y_moving,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [stp_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  logic               held;
  logic               op_held;
  logic signed [15:0] tx_held;
  logic signed [15:0] ty_held;
  logic               advance;
  logic               is_tick;
  logic               next_axis;
  logic [15:0]        patterns;
  logic [3:0]         x_nibble;
  logic [3:0]         y_nibble;
  logic [7:0]         coil_port_next;
  stp_pkg::axis_ctl_t x_ctl, y_ctl;

  assign advance    = held && (!result_valid || !result_stall);
  assign item_stall = held && result_valid && result_stall;
  assign is_tick    = !op_held;

  assign x_ctl = '{load: advance, is_move: op_held, serve: is_tick && !next_axis};
  assign y_ctl = '{load: advance, is_move: op_held, serve: is_tick && next_axis};

  stp_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .patterns (patterns)
  );

  stp_axis u_axis_x (
    .clk         (clk),
    .rst         (rst),
    .ctl         (x_ctl),
    .target      (tx_held),
    .patterns    (patterns),
    .position    (x_position),
    .moving      (x_moving),
    .coil_nibble (x_nibble)
  );

  stp_axis u_axis_y (
    .clk         (clk),
    .rst         (rst),
    .ctl         (y_ctl),
    .target      (ty_held),
    .patterns    (patterns),
    .position    (y_position),
    .moving      (y_moving),
    .coil_nibble (y_nibble)
  );

  // A tick rewrites only the served axis's nibble; a move leaves the port alone.
  always_comb begin
    coil_port_next = coil_port;
    if (is_tick) begin
      if (next_axis) begin
        coil_port_next = {y_nibble, coil_port[3:0]};
      end else begin
        coil_port_next = {coil_port[7:4], x_nibble};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held         <= 1'b0;
      result_valid <= 1'b0;
      next_axis    <= 1'b0;
      coil_port    <= 8'd0;
      served_axis  <= 1'b0;
    end else begin
      if (item_valid && !item_stall) begin
        held <= 1'b1;
      end else if (advance) begin
        held <= 1'b0;
      end
      if (advance) begin
        result_valid <= 1'b1;
        coil_port    <= coil_port_next;
        served_axis  <= is_tick && next_axis;
        if (is_tick) begin
          next_axis <= !next_axis;
        end
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      op_held <= operation;
      tx_held <= target_x;
      ty_held <= target_y;
    end
  end

  `include "two_axis_stepper_positioner_core_macros.svh"

  `STP_ASSERT_NEXT(a_tick_flips_axis, advance && is_tick, next_axis != $past(next_axis),
                   "tick did not hand over to the other axis")
  `STP_ASSERT_NEXT(a_x_tick_keeps_y, advance && is_tick && !next_axis,
                   coil_port[7:4] == $past(coil_port[7:4]),
                   "X tick disturbed the Y coils")
  `STP_ASSERT_NEXT(a_move_keeps_port, advance && !is_tick,
                   coil_port == $past(coil_port) && !served_axis,
                   "move changed the coil port")

endmodule
